/* sv/prdr_pkg.sv */
// Shared types and constants for the pts reorder / dts repair block.
package prdr_pkg;

	localparam int MAX_REORDER = 16;
	localparam int NCELL       = MAX_REORDER + 1;
	localparam int DEPTH_W     = $clog2(MAX_REORDER + 1);
	localparam int CFG_W       = 5;
	localparam int EXT_W       = CFG_W + DEPTH_W;
	localparam int TS_W        = 64;
	localparam int DUR_W       = 32;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_PTS  = 2'd1,
		ST_NO_DUR  = 2'd2,
		ST_NOT_INC = 2'd3
	} status_t;

	typedef struct packed {
		logic                    restart;
		logic                    pts_valid;
		logic signed [TS_W-1:0]  pts;
		logic signed [DUR_W-1:0] frame_duration;
	} in_item_t;

	typedef struct packed {
		logic signed [TS_W-1:0] dts;
		status_t                status;
	} out_item_t;

	// Broadcast to every cell of the window
	typedef struct packed {
		logic                   step_en;
		logic signed [TS_W-1:0] x;
		logic signed [TS_W-1:0] prime_val;
	} cell_bc_t;

	// Per-cell role for the current cycle
	typedef struct packed {
		logic prime_we;
		logic active;
		logic is_top;
	} cell_sel_t;

endpackage

/* sv/prdr_cell.sv */
// One window cell: holds an entry, compares it with the new pts and shifts.
module prdr_cell (
	input  logic                            clk,
	input  prdr_pkg::cell_bc_t              bc,
	input  prdr_pkg::cell_sel_t             sel,
	input  logic signed [prdr_pkg::TS_W-1:0] w_up,
	input  logic                            s_up,
	input  logic signed [prdr_pkg::TS_W-1:0] w_dn,
	input  logic                            s_dn,
	output logic signed [prdr_pkg::TS_W-1:0] w,
	output logic                            s
);
	import prdr_pkg::*;

	logic signed [TS_W-1:0] w_q;
	logic                   lt;

	assign lt = bc.x < w_q;
	// s marks cells above the insertion point
	assign s  = sel.active ? (lt & s_up) : 1'b1;
	assign w  = w_q;

	always_ff @(posedge clk) begin
		if (sel.prime_we) begin
			w_q <= bc.prime_val;
		end else if (bc.step_en) begin
			if (sel.active) begin
				if (s) begin
					w_q <= w_q;
				end else if (s_up) begin
					w_q <= bc.x;
				end else begin
					w_q <= w_up;
				end
			end else if (sel.is_top) begin
				w_q <= s_dn ? w_dn : bc.x;
			end
		end
	end

endmodule

/* sv/pts_reorder_dts_repair.sv */
// Top level: decode timestamp repair over a sorted row of window cells.
// Flow: accept registers the item, step registers the result once the output is
//   free; the first valid item with positive duration after reset or restart
//   primes reorder_depth entries first. Input stalls until the item is stepped.
// Reset: arst_n clears control, primed flag, previous dts and reorder_depth;
//   window entries are not cleared.
module pts_reorder_dts_repair (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [prdr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  prdr_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output prdr_pkg::out_item_t          out_data
);
	import prdr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PRIME = 3'b010,
		S_STEP  = 3'b100
	} state_t;

	state_t                 st_q;
	logic [CFG_W-1:0]       reorder_depth_q;
	logic                   primed_q;
	logic                   prev_valid_q;
	logic signed [TS_W-1:0] prev_dts_q;
	logic                   out_valid_q;
	out_item_t              out_q;
	in_item_t               item_q;
	logic [DEPTH_W-1:0]     cnt_q;
	logic signed [TS_W-1:0] acc_q;

	logic [DEPTH_W-1:0]     depth;
	logic                   in_fire;
	logic                   in_dur_pos;
	logic                   need_prime;
	logic                   step_fire;
	logic                   dur_pos;
	logic                   do_insert;
	logic signed [TS_W-1:0] dur_ext;
	logic signed [TS_W-1:0] acc_nxt;
	logic signed [TS_W-1:0] dts_c;
	out_item_t              res;
	logic                   upd_prev;

	cell_bc_t               bc;
	cell_sel_t              sel   [NCELL];
	logic signed [TS_W-1:0] w_row [NCELL];
	logic                   s_row [NCELL];

	assign depth = (EXT_W'(reorder_depth_q) > EXT_W'(MAX_REORDER)) ?
		DEPTH_W'(MAX_REORDER) : DEPTH_W'(reorder_depth_q);

	assign in_stall   = (st_q != S_IDLE);
	assign in_fire    = in_valid && (st_q == S_IDLE);
	assign in_dur_pos = !in_data.frame_duration[DUR_W-1] && (|in_data.frame_duration);
	assign need_prime = in_data.pts_valid && (!primed_q || in_data.restart) &&
		in_dur_pos && (depth != '0);

	assign dur_pos   = !item_q.frame_duration[DUR_W-1] && (|item_q.frame_duration);
	assign dur_ext   = {{(TS_W-DUR_W){item_q.frame_duration[DUR_W-1]}},
		item_q.frame_duration};
	assign acc_nxt   = acc_q - dur_ext;
	assign step_fire = (st_q == S_STEP) && (!out_valid_q || !out_stall);
	assign do_insert = step_fire && item_q.pts_valid && (primed_q || dur_pos);

	assign bc.step_en   = do_insert;
	assign bc.x         = item_q.pts;
	assign bc.prime_val = acc_nxt;

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		logic signed [TS_W-1:0] w_up;
		logic                   s_up;
		logic signed [TS_W-1:0] w_dn;
		logic                   s_dn;

		assign sel[j].prime_we = (st_q == S_PRIME) && (cnt_q == DEPTH_W'(j));
		assign sel[j].active   = DEPTH_W'(j) < depth;
		assign sel[j].is_top   = DEPTH_W'(j) == depth;

		if (j == NCELL - 1) begin : g_hi
			assign w_up = '0;
			assign s_up = 1'b1;
		end else begin : g_mid
			assign w_up = w_row[j+1];
			assign s_up = s_row[j+1];
		end
		if (j == 0) begin : g_lo
			assign w_dn = '0;
			assign s_dn = 1'b0;
		end else begin : g_nlo
			assign w_dn = w_row[j-1];
			assign s_dn = s_row[j-1];
		end

		prdr_cell u_cell (
			.clk  (clk),
			.bc   (bc),
			.sel  (sel[j]),
			.w_up (w_up),
			.s_up (s_up),
			.w_dn (w_dn),
			.s_dn (s_dn),
			.w    (w_row[j]),
			.s    (s_row[j])
		);
	end

	// Smallest entry after insertion: the new pts if it lands at the bottom
	assign dts_c = s_row[0] ? item_q.pts : w_row[0];

	always_comb begin
		res.dts    = '0;
		res.status = ST_OK;
		upd_prev   = 1'b0;
		if (!item_q.pts_valid) begin
			res.status = ST_NO_PTS;
		end else if (!primed_q && !dur_pos) begin
			res.status = ST_NO_DUR;
		end else begin
			res.dts = dts_c;
			if (prev_valid_q && !(prev_dts_q < dts_c)) begin
				res.status = ST_NOT_INC;
			end else begin
				upd_prev = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= S_IDLE;
			reorder_depth_q <= '0;
			primed_q        <= 1'b0;
			prev_valid_q    <= 1'b0;
			prev_dts_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				reorder_depth_q <= cfg_wdata;
			end
			if (step_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_fire) begin
						// restart takes effect even if this transfer then fails
						if (in_data.restart) begin
							primed_q     <= 1'b0;
							prev_valid_q <= 1'b0;
							prev_dts_q   <= '0;
						end
						st_q <= need_prime ? S_PRIME : S_STEP;
					end
				end
				S_PRIME: begin
					if (cnt_q == '0) begin
						st_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (step_fire) begin
						if (do_insert) begin
							primed_q <= 1'b1;
						end
						if (upd_prev) begin
							prev_dts_q   <= res.dts;
							prev_valid_q <= 1'b1;
						end
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
			acc_q  <= in_data.pts;
			cnt_q  <= depth - DEPTH_W'(1);
		end else if (st_q == S_PRIME) begin
			// advance the running subtract one entry down
			acc_q <= acc_nxt;
			cnt_q <= cnt_q - DEPTH_W'(1);
		end
		if (step_fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> out_valid_q)
		else $error("step did not register a result");

	a_accept_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> in_stall)
		else $error("second transfer accepted before result step");

	a_prev_tracks_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && res.status == ST_OK) |=>
		(primed_q && prev_valid_q && prev_dts_q == $past(res.dts)))
		else $error("previous dts not updated on ok result");

endmodule
